// ----- design/segtree_pkg.sv -----
// Shared constants for the segment tree range sum core.
package segtree_pkg;

    localparam int INDEX_W = 10;
    localparam int RANGE_W = 11;
    localparam int SUM_W   = 26;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef logic [SUM_W-1:0] t_sum;

endpackage

// ----- design/segment_tree_range_sum_core.sv -----
// Segment tree with point update and half-open range sum over one node RAM.
//
//  channel   | direction | signals
//  ----------+-----------+--------------------------------------------------------
//  command   | in/out    | start, busy (out), i_func, i_index, i_value, i_range_start,
//            |           | i_range_end
//  result    | out       | o_valid, o_range_sum
//
// An update writes the leaf, then climbs one level at a time, each step reading the
// sibling from the node RAM and writing the parent. A query reads one node at a time
// via the single RAM read port, shifting both bounds up a level when neither is odd.
// After reset a clearing pass writes zero to all 2 * leaf span nodes, one per cycle,
// with busy high. The result strobe lasts one cycle; the receiver cannot stall.
module segment_tree_range_sum_core #(
    parameter int LEAVES     = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [segtree_pkg::INDEX_W-1:0]     i_index,
    input  logic signed [VALUE_BITS-1:0]        i_value,
    input  logic [segtree_pkg::RANGE_W-1:0]     i_range_start,
    input  logic [segtree_pkg::RANGE_W-1:0]     i_range_end,
    output logic                                o_valid,
    output logic signed [segtree_pkg::SUM_W-1:0] o_range_sum
);

    import segtree_pkg::*;

    localparam int LVL   = $clog2(LEAVES);
    localparam int SPAN  = 1 << LVL;
    localparam int DEPTH = 2 * SPAN;
    localparam int AW    = LVL + 1;
    localparam int PW    = LVL + 2;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_LEAF = 3'd2;
    localparam logic [2:0] S_UP   = 3'd3;
    localparam logic [2:0] S_QRY  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [AW-1:0] r_pos, n_pos;
    t_sum          r_cur, n_cur;
    logic [PW-1:0] r_lo, n_lo;
    logic [PW-1:0] r_hi, n_hi;
    t_sum          r_acc, n_acc;
    logic          r_pend, n_pend;
    t_sum          r_sum, n_sum;
    logic          r_valid, n_valid;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    t_sum          mem_wdata;
    t_sum          mem_rdata;

    logic [31:0]   idx32;
    logic [31:0]   st32;
    logic [31:0]   end32;
    logic [31:0]   hic32;
    logic signed [31:0] val32;
    t_sum          acc_sum;
    t_sum          up_sum;
    logic [AW-1:0] parent;

    segtree_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign idx32   = 32'(i_index);
    assign st32    = 32'(i_range_start);
    assign end32   = 32'(i_range_end);
    assign hic32   = (end32 > 32'(LEAVES)) ? 32'(LEAVES) : end32;
    assign val32   = 32'(i_value);
    assign acc_sum = r_pend ? (r_acc + mem_rdata) : r_acc;
    assign up_sum  = r_cur + mem_rdata;
    assign parent  = r_pos >> 1;

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_pos     = r_pos;
        n_cur     = r_cur;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_acc     = r_acc;
        n_pend    = r_pend;
        n_sum     = r_sum;
        n_valid   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_cur;
        mem_raddr = '0;

        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_func == FUNC_UPDATE) begin
                        if (idx32 < 32'(LEAVES)) begin
                            n_pos   = {1'b1, idx32[LVL-1:0]};
                            n_cur   = val32[SUM_W-1:0];
                            n_state = S_LEAF;
                        end
                    end else begin
                        n_acc  = '0;
                        n_pend = 1'b0;
                        if (st32 < hic32) begin
                            n_lo = PW'(SPAN) + st32[PW-1:0];
                            n_hi = PW'(SPAN) + hic32[PW-1:0];
                        end else begin
                            n_lo = '0;
                            n_hi = '0;
                        end
                        n_state = S_QRY;
                    end
                end
            end
            S_LEAF: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_cur;
                mem_raddr = r_pos ^ AW'(1);
                n_state   = S_UP;
            end
            S_UP: begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = up_sum;
                mem_raddr = parent ^ AW'(1);
                n_cur     = up_sum;
                n_pos     = parent;
                if (parent == AW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_QRY: begin
                n_acc = acc_sum;
                priority if (r_lo >= r_hi) begin
                    n_sum   = acc_sum;
                    n_valid = 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end else if (r_lo[0]) begin
                    mem_raddr = r_lo[AW-1:0];
                    n_lo      = r_lo + 1'b1;
                    n_pend    = 1'b1;
                end else if (r_hi[0]) begin
                    mem_raddr = AW'(r_hi - 1'b1);
                    n_hi      = r_hi - 1'b1;
                    n_pend    = 1'b1;
                end else begin
                    n_lo   = r_lo >> 1;
                    n_hi   = r_hi >> 1;
                    n_pend = 1'b0;
                end
            end
            default: begin
                n_state = S_CLR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
        r_pos <= n_pos;
        r_cur <= n_cur;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_acc <= n_acc;
        r_sum <= n_sum;
    end

    assign busy        = (r_state != S_IDLE) || !i_rst_n;
    assign o_valid     = r_valid;
    assign o_range_sum = r_sum;

    a_valid_after_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state) == S_QRY)
        else $error("result strobe without a finished query");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_QRY) |-> !mem_we)
        else $error("node write outside clear or update");

    a_rw_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state != S_CLR) |-> mem_raddr != mem_waddr)
        else $error("read and write of the same node in one cycle");

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_QRY |-> r_lo <= r_hi)
        else $error("query bounds crossed");

endmodule

// ----- design/segtree_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module segtree_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- dv/segment_tree_range_sum_core_test.sv -----
// Self-checking testbench for the segment tree range sum core: leaf writes and range-sum queries.
`timescale 1ns / 100ps

module segment_tree_range_sum_core_test;
    import segtree_pkg::*;

    localparam int LEAVES      = 1024;
    localparam int VALUE_BITS  = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 64;
    localparam int REPORT_MAX  = 10;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic                        i_func;
    logic [INDEX_W-1:0]          i_index;
    logic signed [VALUE_BITS-1:0] i_value;
    logic [RANGE_W-1:0]          i_range_start;
    logic [RANGE_W-1:0]          i_range_end;
    logic                        o_valid;
    logic signed [SUM_W-1:0]     o_range_sum;

    logic signed [VALUE_BITS-1:0] leaf_values [LEAVES];
    t_sum                         pending_sums [$];
    int                           mismatch_count;
    int                           checked_sums;
    int                           leaf_writes;
    int                           range_queries;
    int                           cycle_count;
    bit                           idle_allowed;

    segment_tree_range_sum_core #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_index       (i_index),
        .i_value       (i_value),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .o_valid       (o_valid),
        .o_range_sum   (o_range_sum)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_sum expected_range_sum(logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
        int first;
        int last;
        int acc;
        first = int'(lo);
        last  = (int'(hi) > LEAVES) ? LEAVES : int'(hi);
        acc   = 0;
        for (int k = first; k < last; k++) begin
            acc += int'(leaf_values[k]);
        end
        return t_sum'(acc);
    endfunction

    task automatic send_word(logic func, logic [INDEX_W-1:0] idx, logic [VALUE_BITS-1:0] val,
                             logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
        @(negedge i_clk);
        start         <= 1'b1;
        i_func        <= func;
        i_index       <= idx;
        i_value       <= val;
        i_range_start <= lo;
        i_range_end   <= hi;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        if (func == FUNC_UPDATE) begin
            leaf_values[idx] = val;
            leaf_writes++;
        end else begin
            pending_sums.push_back(expected_range_sum(lo, hi));
            range_queries++;
        end
    endtask

    task automatic write_leaf(logic [INDEX_W-1:0] idx, logic [VALUE_BITS-1:0] val);
        send_word(FUNC_UPDATE, idx, val, RANGE_W'($urandom), RANGE_W'($urandom));
    endtask

    task automatic query_sum(logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
        send_word(FUNC_QUERY, INDEX_W'($urandom), VALUE_BITS'($urandom), lo, hi);
    endtask

    task automatic hold_off(int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic maybe_idle();
        if (idle_allowed && $urandom_range(0, 3) == 0) begin
            hold_off($urandom_range(1, 11));
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_sum want;
        if (i_rst_n && o_valid) begin
            if (pending_sums.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("unexpected range sum %0d at cycle %0d", o_range_sum, cycle_count);
                end
            end else begin
                want = pending_sums.pop_front();
                checked_sums++;
                if (o_range_sum !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("range_sum mismatch: expected %0d actual %0d at cycle %0d",
                                 $signed(want), o_range_sum, cycle_count);
                    end
                end
            end
        end
    end

    task automatic test_directed_edges();
        query_sum(11'd0, RANGE_W'(LEAVES));
        write_leaf(10'd0, 16'h7FFF);
        write_leaf(INDEX_W'(LEAVES - 1), 16'h8000);
        write_leaf(10'd512, 16'hFFFF);
        write_leaf(10'h155, 16'h5555);
        write_leaf(10'h2AA, 16'hAAAA);
        query_sum(11'd0, RANGE_W'(LEAVES));
        query_sum(11'd0, 11'd1);
        query_sum(RANGE_W'(LEAVES - 1), RANGE_W'(LEAVES));
        query_sum(11'd0, 11'h7FF);
        query_sum(11'h7FF, 11'h7FF);
        query_sum(11'h7FF, 11'd0);
        query_sum(11'd5, 11'd5);
        query_sum(11'd1000, 11'd3);
        query_sum(RANGE_W'(LEAVES), 11'h7FF);
        query_sum(11'd0, 11'd0);
        query_sum(11'd512, 11'd513);
        query_sum(11'd1, RANGE_W'(LEAVES - 1));
        query_sum(11'h2AA, 11'h555);
        write_leaf(10'd0, 16'h0000);
        write_leaf(10'd512, 16'h0001);
        query_sum(11'd0, 11'd600);
        hold_off($urandom_range(1, 11));
        query_sum(11'd0, RANGE_W'(LEAVES));
    endtask

    task automatic test_full_scale_fill();
        for (int k = LEAVES / 2; k < LEAVES; k++) begin
            write_leaf(INDEX_W'(k), 16'h8000);
        end
        query_sum(11'd0, RANGE_W'(LEAVES));
        query_sum(11'd0, 11'h7FF);
        query_sum(RANGE_W'(LEAVES / 2), RANGE_W'(LEAVES));
        query_sum(11'd256, 11'd768);
        drain_results();
    endtask

    task automatic test_random_traffic(int items);
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;
        logic [VALUE_BITS-1:0] val;
        int a;
        int b;
        for (int n = 0; n < items; n++) begin
            idle_allowed = (n < items - items / 5);
            maybe_idle();
            if (idle_allowed && n % 250 == 249) drain_results();
            if ($urandom_range(0, 99) < 45) begin
                case ($urandom_range(0, 9))
                    0:       val = 16'h8000;
                    1:       val = 16'h7FFF;
                    2:       val = 16'h0000;
                    default: val = VALUE_BITS'($urandom);
                endcase
                write_leaf(INDEX_W'($urandom_range(0, LEAVES - 1)), val);
            end else begin
                a = $urandom_range(0, LEAVES);
                b = $urandom_range(0, LEAVES);
                case ($urandom_range(0, 9))
                    0: begin
                        lo = RANGE_W'($urandom);
                        hi = RANGE_W'($urandom);
                    end
                    1: begin
                        lo = RANGE_W'((a > b) ? a : b);
                        hi = RANGE_W'((a > b) ? b : a);
                    end
                    2: begin
                        lo = RANGE_W'(a);
                        hi = RANGE_W'(a + $urandom_range(0, 3));
                    end
                    default: begin
                        lo = RANGE_W'((a < b) ? a : b);
                        hi = RANGE_W'((a < b) ? b : a);
                    end
                endcase
                query_sum(lo, hi);
            end
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_func         = FUNC_UPDATE;
        i_index        = '0;
        i_value        = '0;
        i_range_start  = '0;
        i_range_end    = '0;
        mismatch_count = 0;
        checked_sums   = 0;
        leaf_writes    = 0;
        range_queries  = 0;
        idle_allowed   = 1'b1;
        for (int k = 0; k < LEAVES; k++) leaf_values[k] = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_full_scale_fill();
        test_random_traffic(450);

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (pending_sums.size() != 0) begin
            mismatch_count++;
            $display("%0d range sums never arrived", pending_sums.size());
        end
        $display("covered %0d leaf writes and %0d range queries, %0d sums checked",
                 leaf_writes, range_queries, checked_sums);
        $display("ranges included full, clamped, empty and reversed spans; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
